FILE: rtl/eartm_pkg.sv
// Package for the Euler angle to rotation matrix pipeline.
// Holds CORDIC constants, the arctangent table and shared widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package eartm_pkg;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned CordicW = 33;
  localparam logic signed [CordicW-1:0] CordicGain = 33'sd652032874;
  localparam int unsigned OutW = 16;

  typedef logic signed [CordicW-1:0] cval_t;

  function automatic cval_t atan_turn(input logic [4:0] idx);
    cval_t r;
    r = '0;
    case (idx)
      5'd0: r = 33'sh20000000;
      5'd1: r = 33'sh12E4051E;
      5'd2: r = 33'sh09FB385B;
      5'd3: r = 33'sh051111D4;
      5'd4: r = 33'sh028B0D43;
      5'd5: r = 33'sh0145D7E1;
      5'd6: r = 33'sh00A2F61E;
      5'd7: r = 33'sh00517C55;
      5'd8: r = 33'sh0028BE53;
      5'd9: r = 33'sh00145F2F;
      5'd10: r = 33'sh000A2F98;
      5'd11: r = 33'sh000517CC;
      5'd12: r = 33'sh00028BE6;
      5'd13: r = 33'sh000145F3;
      5'd14: r = 33'sh0000A2FA;
      5'd15: r = 33'sh0000517D;
      5'd16: r = 33'sh000028BE;
      5'd17: r = 33'sh0000145F;
      5'd18: r = 33'sh00000A30;
      5'd19: r = 33'sh00000518;
      5'd20: r = 33'sh0000028C;
      5'd21: r = 33'sh00000146;
      5'd22: r = 33'sh000000A3;
      5'd23: r = 33'sh00000051;
      5'd24: r = 33'sh00000029;
      5'd25: r = 33'sh00000014;
      5'd26: r = 33'sh0000000A;
      5'd27: r = 33'sh00000005;
      5'd28: r = 33'sh00000003;
      5'd29: r = 33'sh00000001;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/euler_angles_to_rotation_matrix.sv
// Top level: Euler angles to 3x3 rotation matrix in signed Q FRAC_BITS.
// done_o is start delayed through vld_q; throughput one transaction per cycle.
// busy is always low since the receiver cannot stall the pipeline.
// Reset clears only the valid pipeline; data registers are not reset.
// Depends on eartm_pkg, eartm_cordic and eartm_matrix.
`timescale 1ns / 1ps
`default_nettype none
module euler_angles_to_rotation_matrix #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  output logic                  busy,
  input  wire  [ANGLE_BITS-1:0] yaw_angle_i,
  input  wire  [ANGLE_BITS-1:0] pitch_angle_i,
  input  wire  [ANGLE_BITS-1:0] roll_angle_i,
  output logic                  done_o,
  output logic signed [15:0]    r0c0_o,
  output logic signed [15:0]    r0c1_o,
  output logic signed [15:0]    r0c2_o,
  output logic signed [15:0]    r1c0_o,
  output logic signed [15:0]    r1c1_o,
  output logic signed [15:0]    r1c2_o,
  output logic signed [15:0]    r2c0_o,
  output logic signed [15:0]    r2c1_o,
  output logic signed [15:0]    r2c2_o
);
  import eartm_pkg::*;

  localparam int unsigned Lat = CordicSteps + 2 + 5;

  cval_t sy, cy, sp, cp, sr, cr;
  logic signed [15:0] r [9];
  logic [Lat-1:0] vld_q;

  assign busy = 1'b0;

  eartm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk_i, .en_i(1'b1), .angle_i(yaw_angle_i), .sin_o(sy), .cos_o(cy));
  eartm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk_i, .en_i(1'b1), .angle_i(pitch_angle_i), .sin_o(sp), .cos_o(cp));
  eartm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk_i, .en_i(1'b1), .angle_i(roll_angle_i), .sin_o(sr), .cos_o(cr));

  eartm_matrix #(.FRAC_BITS(FRAC_BITS)) u_mat (
    .clk_i, .en_i(1'b1),
    .sy_i(sy), .cy_i(cy), .sp_i(sp), .cp_i(cp), .sr_i(sr), .cr_i(cr), .r_o(r));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
    end
  end

  assign done_o = vld_q[Lat-1];
  assign r0c0_o = r[0];
  assign r0c1_o = r[1];
  assign r0c2_o = r[2];
  assign r1c0_o = r[3];
  assign r1c1_o = r[4];
  assign r1c2_o = r[5];
  assign r2c0_o = r[6];
  assign r2c1_o = r[7];
  assign r2c2_o = r[8];
endmodule
`default_nettype wire

FILE: rtl/eartm_cordic.sv
// Pipelined CORDIC sine and cosine in Q30, one rotation step per stage.
// Depends on eartm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eartm_cordic #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  wire                         clk_i,
  input  wire                         en_i,
  input  wire  [ANGLE_BITS-1:0]       angle_i,
  output eartm_pkg::cval_t            sin_o,
  output eartm_pkg::cval_t            cos_o
);
  import eartm_pkg::*;

  localparam int unsigned N = CordicSteps;

  cval_t      x_q [N+1];
  cval_t      y_q [N+1];
  cval_t      z_q [N+1];
  logic [1:0] quad_q [N+1];
  cval_t      sin_q, cos_q;

  logic [31:0] a32;
  logic [31:0] b;

  assign a32 = {angle_i, {(32-ANGLE_BITS){1'b0}}};
  assign b = a32 + 32'h2000_0000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CordicGain;
      y_q[0] <= '0;
      z_q[0] <= $signed({3'b000, b[29:0]}) - 33'sh20000000;
      quad_q[0] <= b[31:30];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    cval_t xs, ys, at;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = atan_turn(5'(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][CordicW-1]) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + at;
        end
        quad_q[i+1] <= quad_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (quad_q[N])
        2'd0: begin cos_q <= x_q[N];  sin_q <= y_q[N];  end
        2'd1: begin cos_q <= -y_q[N]; sin_q <= x_q[N];  end
        2'd2: begin cos_q <= -x_q[N]; sin_q <= -y_q[N]; end
        default: begin cos_q <= y_q[N]; sin_q <= -x_q[N]; end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;
endmodule
`default_nettype wire

FILE: rtl/eartm_matrix.sv
// Product, rounding and saturation stages that form the nine matrix entries.
// Depends on eartm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eartm_matrix #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire                      clk_i,
  input  wire                      en_i,
  input  eartm_pkg::cval_t         sy_i,
  input  eartm_pkg::cval_t         cy_i,
  input  eartm_pkg::cval_t         sp_i,
  input  eartm_pkg::cval_t         cp_i,
  input  eartm_pkg::cval_t         sr_i,
  input  eartm_pkg::cval_t         cr_i,
  output logic signed [15:0]       r_o [9]
);
  import eartm_pkg::*;

  localparam int unsigned PW = 2 * CordicW;
  localparam int unsigned Sh = 60 - FRAC_BITS;

  // Stage 1: sr*sp, cr*sp, and keep others.
  logic signed [PW-1:0] srsp_p_q, crsp_p_q;
  cval_t sy1_q, cy1_q, sp1_q, cp1_q, sr1_q, cr1_q;
  // Stage 2: round to Q30.
  cval_t srsp2_q, crsp2_q, sy2_q, cy2_q, sp2_q, cp2_q, sr2_q, cr2_q;
  // Stage 3: all products in Q60.
  logic signed [PW-1:0] p_q [13];
  // Stage 4: sums.
  logic signed [PW:0]   s_q [9];
  logic signed [15:0]   r_q [9];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      srsp_p_q <= sr_i * sp_i;
      crsp_p_q <= cr_i * sp_i;
      sy1_q <= sy_i; cy1_q <= cy_i; sp1_q <= sp_i;
      cp1_q <= cp_i; sr1_q <= sr_i; cr1_q <= cr_i;

      srsp2_q <= CordicW'((srsp_p_q + (PW'(1) <<< 29)) >>> 30);
      crsp2_q <= CordicW'((crsp_p_q + (PW'(1) <<< 29)) >>> 30);
      sy2_q <= sy1_q; cy2_q <= cy1_q; sp2_q <= sp1_q;
      cp2_q <= cp1_q; sr2_q <= sr1_q; cr2_q <= cr1_q;

      p_q[0]  <= cp2_q * cy2_q;
      p_q[1]  <= cp2_q * sy2_q;
      p_q[2]  <= -(PW'(sp2_q) <<< 30);
      p_q[3]  <= srsp2_q * cy2_q;
      p_q[4]  <= cr2_q * sy2_q;
      p_q[5]  <= srsp2_q * sy2_q;
      p_q[6]  <= cr2_q * cy2_q;
      p_q[7]  <= sr2_q * cp2_q;
      p_q[8]  <= crsp2_q * cy2_q;
      p_q[9]  <= sr2_q * sy2_q;
      p_q[10] <= crsp2_q * sy2_q;
      p_q[11] <= sr2_q * cy2_q;
      p_q[12] <= cr2_q * cp2_q;

      s_q[0] <= (PW+1)'(p_q[0]);
      s_q[1] <= (PW+1)'(p_q[1]);
      s_q[2] <= (PW+1)'(p_q[2]);
      s_q[3] <= (PW+1)'(p_q[3]) - (PW+1)'(p_q[4]);
      s_q[4] <= (PW+1)'(p_q[5]) + (PW+1)'(p_q[6]);
      s_q[5] <= (PW+1)'(p_q[7]);
      s_q[6] <= (PW+1)'(p_q[8]) + (PW+1)'(p_q[9]);
      s_q[7] <= (PW+1)'(p_q[10]) - (PW+1)'(p_q[11]);
      s_q[8] <= (PW+1)'(p_q[12]);
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_out
    logic signed [PW:0] rnd;
    logic signed [PW:0] one;
    logic signed [15:0] sat;
    assign rnd = (s_q[k] + ((PW+1)'(1) <<< (Sh - 1))) >>> Sh;
    assign one = (PW+1)'(1) <<< FRAC_BITS;
    always_comb begin
      if (rnd > one) begin
        sat = 16'(one);
      end else if (rnd < -one) begin
        sat = 16'(-one);
      end else begin
        sat = 16'(rnd);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= sat;
      end
    end
    assign r_o[k] = r_q[k];
  end
endmodule
`default_nettype wire
